// ===== hw/rtl/ape_pkg.sv =====
`default_nettype none

package ape_pkg;

    localparam int DataW = 32;
    localparam int ProdW = 64;
    localparam int MulW  = 33;
    localparam int WideW = 50;
    localparam int StepW = 4;
    localparam int CntW  = 4;
    localparam int AddrW = 5;
    localparam int RootW = 16;

    // multiplier operand selection
    localparam logic [2:0] MUL_NONE       = 3'd0;
    localparam logic [2:0] MUL_BETA_DRIVE = 3'd1;
    localparam logic [2:0] MUL_GA_S       = 3'd2;
    localparam logic [2:0] MUL_GB_S       = 3'd3;
    localparam logic [2:0] MUL_KA_E       = 3'd4;
    localparam logic [2:0] MUL_KB_DRIVE   = 3'd5;
    localparam logic [2:0] MUL_T_E        = 3'd6;

    // destination of the post-multiply write-back
    localparam logic [2:0] DST_NONE  = 3'd0;
    localparam logic [2:0] DST_ERR   = 3'd1;
    localparam logic [2:0] DST_KA    = 3'd2;
    localparam logic [2:0] DST_KB    = 3'd3;
    localparam logic [2:0] DST_ALPHA = 3'd4;
    localparam logic [2:0] DST_T     = 3'd5;
    localparam logic [2:0] DST_BETA  = 3'd6;

    // sequencing
    localparam logic [1:0] SEQ_NEXT    = 2'd0;
    localparam logic [1:0] SEQ_WAIT_IN = 2'd1;
    localparam logic [1:0] SEQ_SQRT    = 2'd2;
    localparam logic [1:0] SEQ_EMIT    = 2'd3;

    // program steps
    localparam logic [StepW-1:0] STEP_IDLE   = 4'd0;
    localparam logic [StepW-1:0] STEP_PRED   = 4'd1;
    localparam logic [StepW-1:0] STEP_ERR    = 4'd2;
    localparam logic [StepW-1:0] STEP_SQRT   = 4'd3;
    localparam logic [StepW-1:0] STEP_GA     = 4'd4;
    localparam logic [StepW-1:0] STEP_GB     = 4'd5;
    localparam logic [StepW-1:0] STEP_DA     = 4'd6;
    localparam logic [StepW-1:0] STEP_ALPHA  = 4'd7;
    localparam logic [StepW-1:0] STEP_T      = 4'd8;
    localparam logic [StepW-1:0] STEP_DB     = 4'd9;
    localparam logic [StepW-1:0] STEP_BETA   = 4'd10;
    localparam logic [StepW-1:0] STEP_EMIT   = 4'd11;

    // register map indexes
    localparam logic [2:0] REG_GAIN_ALPHA = 3'd0;
    localparam logic [2:0] REG_GAIN_BETA  = 3'd1;
    localparam logic [2:0] REG_BETA_LOW   = 3'd2;
    localparam logic [2:0] REG_BETA_HIGH  = 3'd3;
    localparam logic [2:0] REG_INIT_ALPHA = 3'd4;
    localparam logic [2:0] REG_INIT_BETA  = 3'd5;

    localparam logic [DataW-1:0] RST_GAIN_ALPHA = 32'd42950;
    localparam logic [DataW-1:0] RST_GAIN_BETA  = 32'd429496730;
    localparam logic [DataW-1:0] RST_BETA_LOW   = 32'd6554;
    localparam logic [DataW-1:0] RST_BETA_HIGH  = 32'd131072;
    localparam logic [DataW-1:0] RST_INIT_ALPHA = 32'd0;
    localparam logic [DataW-1:0] RST_INIT_BETA  = 32'd65536;

    localparam logic [DataW-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DataW-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [2:0] mul_sel;
        logic [2:0] dst;
        logic [1:0] seq;
    } ctrl_word_t;

    // Microprogram: one control word per step.
    function automatic ctrl_word_t ape_ucode(input logic [StepW-1:0] step);
        ctrl_word_t w;
        case (step)
            STEP_IDLE:  w = '{mul_sel: MUL_NONE,       dst: DST_NONE,  seq: SEQ_WAIT_IN};
            STEP_PRED:  w = '{mul_sel: MUL_BETA_DRIVE, dst: DST_NONE,  seq: SEQ_NEXT};
            STEP_ERR:   w = '{mul_sel: MUL_NONE,       dst: DST_ERR,   seq: SEQ_NEXT};
            STEP_SQRT:  w = '{mul_sel: MUL_NONE,       dst: DST_NONE,  seq: SEQ_SQRT};
            STEP_GA:    w = '{mul_sel: MUL_GA_S,       dst: DST_NONE,  seq: SEQ_NEXT};
            STEP_GB:    w = '{mul_sel: MUL_GB_S,       dst: DST_KA,    seq: SEQ_NEXT};
            STEP_DA:    w = '{mul_sel: MUL_KA_E,       dst: DST_KB,    seq: SEQ_NEXT};
            STEP_ALPHA: w = '{mul_sel: MUL_KB_DRIVE,   dst: DST_ALPHA, seq: SEQ_NEXT};
            STEP_T:     w = '{mul_sel: MUL_NONE,       dst: DST_T,     seq: SEQ_NEXT};
            STEP_DB:    w = '{mul_sel: MUL_T_E,        dst: DST_NONE,  seq: SEQ_NEXT};
            STEP_BETA:  w = '{mul_sel: MUL_NONE,       dst: DST_BETA,  seq: SEQ_NEXT};
            STEP_EMIT:  w = '{mul_sel: MUL_NONE,       dst: DST_NONE,  seq: SEQ_EMIT};
            default:    w = '{mul_sel: MUL_NONE,       dst: DST_NONE,  seq: SEQ_NEXT};
        endcase
        return w;
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic logic [DataW-1:0] sat_to_32(input logic signed [WideW-1:0] v);
        logic fits;
        fits = (v[WideW-1:DataW-1] == '0) || (v[WideW-1:DataW-1] == '1);
        if (fits)
            return v[DataW-1:0];
        else if (v[WideW-1])
            return SAT_MIN;
        else
            return SAT_MAX;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ape_channels.sv =====
`default_nettype none

interface ape_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [ape_pkg::DataW-1:0]   accel;
    logic signed [ape_pkg::DataW-1:0]   drive;
    logic        [ape_pkg::DataW-1:0]   period;
    logic                               reload;

    modport source (output valid, accel, drive, period, reload, input ready);
    modport sink   (input valid, accel, drive, period, reload, output ready);
endinterface

interface ape_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ape_pkg::DataW-1:0]   alpha_out;
    logic signed [ape_pkg::DataW-1:0]   beta_out;

    modport source (output valid, alpha_out, beta_out, input ready);
    modport sink   (input valid, alpha_out, beta_out, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/adaptive_param_estimator_1d_core.sv =====
// Online LMS estimator of acc = alpha + beta*drive (Q16.16 values).
// Input channel in_ch carries accel, drive, period (Q0.32) and reload;
// one transaction in gives exactly one transaction on out_ch with the
// updated alpha_out (saturated) and beta_out (clamped to beta_low/high).
// Gains, clamps and init values sit behind the APB port at 4*index;
// write them only while no transaction is in flight.
// Control is a 12-step microprogram over one shared 33x33 multiplier and
// a one-bit-pair-per-cycle square root unit. Before out_ch.valid rises, a
// transaction runs the root iterations, six multiplies, their write-backs
// and the emit. Only one transaction is in flight: the next input is
// accepted once the previous one has been emitted.
// A new input is taken while the previous result still waits on out_ch;
// when the receiver stalls, the block holds in its final step until the
// output register frees, so no result is lost or overwritten.
// Reset (rst_n low, asynchronous) restores the config, step, count and
// out_valid registers and loads alpha and beta from the init reset values.
`default_nettype none

module adaptive_param_estimator_1d_core
    import ape_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    ape_in_if.sink                 in_ch,
    ape_out_if.source              out_ch,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [AddrW-1:0]  paddr,
    input  wire logic [DataW-1:0]  pwdata,
    output logic      [DataW-1:0]  prdata,
    output logic                   pready
);

    // ---------------- configuration registers ----------------
    logic [DataW-1:0] gain_alpha_reg, gain_alpha_next;
    logic [DataW-1:0] gain_beta_reg,  gain_beta_next;
    logic [DataW-1:0] beta_low_reg,   beta_low_next;
    logic [DataW-1:0] beta_high_reg,  beta_high_next;
    logic [DataW-1:0] init_alpha_reg, init_alpha_next;
    logic [DataW-1:0] init_beta_reg,  init_beta_next;

    logic             cfg_wr;
    logic [2:0]       cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[AddrW-1:2];

    always_comb
    begin
        gain_alpha_next = gain_alpha_reg;
        gain_beta_next  = gain_beta_reg;
        beta_low_next   = beta_low_reg;
        beta_high_next  = beta_high_reg;
        init_alpha_next = init_alpha_reg;
        init_beta_next  = init_beta_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_GAIN_ALPHA: gain_alpha_next = pwdata;
                REG_GAIN_BETA:  gain_beta_next  = pwdata;
                REG_BETA_LOW:   beta_low_next   = pwdata;
                REG_BETA_HIGH:  beta_high_next  = pwdata;
                REG_INIT_ALPHA: init_alpha_next = pwdata;
                REG_INIT_BETA:  init_beta_next  = pwdata;
                default:        ;  // unmapped: drop the write
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_GAIN_ALPHA: prdata = gain_alpha_reg;
            REG_GAIN_BETA:  prdata = gain_beta_reg;
            REG_BETA_LOW:   prdata = beta_low_reg;
            REG_BETA_HIGH:  prdata = beta_high_reg;
            REG_INIT_ALPHA: prdata = init_alpha_reg;
            REG_INIT_BETA:  prdata = init_beta_reg;
            default:        prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    logic [StepW-1:0] step_reg, step_next;
    ctrl_word_t       cw;
    logic             in_acc;
    logic             out_free;
    logic             emit;

    logic [CntW-1:0]  cnt_reg, cnt_next;

    assign cw       = ape_ucode(step_reg);
    assign in_ch.ready = (cw.seq == SEQ_WAIT_IN);
    assign in_acc   = in_ch.valid && in_ch.ready;
    assign out_free = !out_ch.valid || out_ch.ready;
    assign emit     = (cw.seq == SEQ_EMIT) && out_free;

    always_comb
    begin
        step_next = step_reg;
        case (cw.seq)
            SEQ_WAIT_IN:
            begin
                if (in_acc)
                    step_next = step_reg + 1'b1;
            end
            SEQ_SQRT:
            begin
                // stay on the root step until the last bit pair
                if (cnt_reg == '0)
                    step_next = step_reg + 1'b1;
            end
            SEQ_EMIT:
            begin
                if (out_free)
                    step_next = STEP_IDLE;
            end
            default:
                step_next = step_reg + 1'b1;
        endcase
    end

    // ---------------- datapath ----------------
    logic signed [DataW-1:0] accel_reg,  accel_next;
    logic signed [DataW-1:0] drive_reg,  drive_next;
    logic signed [DataW-1:0] alpha_reg,  alpha_next;
    logic signed [DataW-1:0] beta_reg,   beta_next;
    logic signed [DataW-1:0] err_reg,    err_next;
    logic        [DataW-1:0] ka_reg,     ka_next;
    logic        [DataW-1:0] kb_reg,     kb_next;
    logic signed [DataW-1:0] t_reg,      t_next;
    logic signed [ProdW-1:0] prod_reg,   prod_next;
    logic        [DataW-1:0] rem_reg,    rem_next;
    logic        [DataW-1:0] root_reg,   root_next;

    logic signed [MulW-1:0]    mul_a, mul_b;
    logic signed [2*MulW-1:0]  mul_full;

    logic signed [WideW-1:0]   err_wide;
    logic signed [WideW-1:0]   alpha_wide;
    logic signed [WideW-2:0]   beta_wide, beta_lo_w, beta_hi_w, beta_c1, beta_c2;

    logic        [DataW-1:0]   sq_bit;
    logic        [DataW:0]     sq_trial;

    // multiplier operand select
    always_comb
    begin
        case (cw.mul_sel)
            MUL_BETA_DRIVE:
            begin
                mul_a = MulW'(beta_reg);
                mul_b = MulW'(drive_reg);
            end
            MUL_GA_S:
            begin
                mul_a = {1'b0, gain_alpha_reg};
                mul_b = {{(MulW-RootW){1'b0}}, root_reg[RootW-1:0]};
            end
            MUL_GB_S:
            begin
                mul_a = {1'b0, gain_beta_reg};
                mul_b = {{(MulW-RootW){1'b0}}, root_reg[RootW-1:0]};
            end
            MUL_KA_E:
            begin
                mul_a = {1'b0, ka_reg};
                mul_b = MulW'(err_reg);
            end
            MUL_KB_DRIVE:
            begin
                mul_a = {1'b0, kb_reg};
                mul_b = MulW'(drive_reg);
            end
            MUL_T_E:
            begin
                mul_a = MulW'(t_reg);
                mul_b = MulW'(err_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // e = accel - (alpha + (beta*drive >>> 16)), saturated
    assign err_wide = WideW'(accel_reg)
                    - (WideW'(alpha_reg) + WideW'($signed(prod_reg[ProdW-1:16])));

    // alpha + (ka*e >>> 32)
    assign alpha_wide = WideW'(alpha_reg) + WideW'($signed(prod_reg[ProdW-1:DataW]));

    // beta + (t*e >>> 16), then lower clamp, then upper clamp
    assign beta_wide = (WideW-1)'(beta_reg) + (WideW-1)'($signed(prod_reg[ProdW-1:16]));
    assign beta_lo_w = (WideW-1)'($signed(beta_low_reg));
    assign beta_hi_w = (WideW-1)'($signed(beta_high_reg));
    assign beta_c1   = (beta_wide < beta_lo_w) ? beta_lo_w : beta_wide;
    assign beta_c2   = (beta_c1 > beta_hi_w) ? beta_hi_w : beta_c1;

    // one bit pair of the restoring square root per cycle
    assign sq_bit   = DataW'(1) << {cnt_reg, 1'b0};
    assign sq_trial = {1'b0, root_reg} + {1'b0, sq_bit};

    always_comb
    begin
        accel_next = accel_reg;
        drive_next = drive_reg;
        alpha_next = alpha_reg;
        beta_next  = beta_reg;
        err_next   = err_reg;
        ka_next    = ka_reg;
        kb_next    = kb_reg;
        t_next     = t_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;

        if (in_acc)
        begin
            accel_next = in_ch.accel;
            drive_next = in_ch.drive;
            rem_next   = in_ch.period;
            root_next  = '0;
            cnt_next   = '1;
            if (in_ch.reload)
            begin
                alpha_next = init_alpha_reg;
                beta_next  = init_beta_reg;
            end
        end

        if (cw.seq == SEQ_SQRT)
        begin
            if ({1'b0, rem_reg} >= sq_trial)
            begin
                rem_next  = rem_reg - sq_trial[DataW-1:0];
                root_next = (root_reg >> 1) + sq_bit;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            cnt_next = cnt_reg - 1'b1;
        end

        if (cw.mul_sel != MUL_NONE)
            prod_next = mul_full[ProdW-1:0];

        case (cw.dst)
            DST_ERR:   err_next   = sat_to_32(err_wide);
            DST_KA:    ka_next    = prod_reg[DataW+15:16];
            DST_KB:    kb_next    = prod_reg[DataW+15:16];
            DST_ALPHA: alpha_next = sat_to_32(alpha_wide);
            DST_T:     t_next     = prod_reg[ProdW-1:DataW];
            DST_BETA:  beta_next  = beta_c2[DataW-1:0];
            default:   ;
        endcase
    end

    // ---------------- output register ----------------
    logic                    out_valid_reg, out_valid_next;
    logic signed [DataW-1:0] alpha_out_reg, alpha_out_next;
    logic signed [DataW-1:0] beta_out_reg,  beta_out_next;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        alpha_out_next = alpha_out_reg;
        beta_out_next  = beta_out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            alpha_out_next = alpha_reg;
            beta_out_next  = beta_reg;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.alpha_out = alpha_out_reg;
    assign out_ch.beta_out  = beta_out_reg;

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_alpha_reg <= RST_GAIN_ALPHA;
            gain_beta_reg  <= RST_GAIN_BETA;
            beta_low_reg   <= RST_BETA_LOW;
            beta_high_reg  <= RST_BETA_HIGH;
            init_alpha_reg <= RST_INIT_ALPHA;
            init_beta_reg  <= RST_INIT_BETA;
            alpha_reg      <= RST_INIT_ALPHA;
            beta_reg       <= RST_INIT_BETA;
            step_reg       <= STEP_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            gain_alpha_reg <= gain_alpha_next;
            gain_beta_reg  <= gain_beta_next;
            beta_low_reg   <= beta_low_next;
            beta_high_reg  <= beta_high_next;
            init_alpha_reg <= init_alpha_next;
            init_beta_reg  <= init_beta_next;
            alpha_reg      <= alpha_next;
            beta_reg       <= beta_next;
            step_reg       <= step_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        accel_reg     <= accel_next;
        drive_reg     <= drive_next;
        err_reg       <= err_next;
        ka_reg        <= ka_next;
        kb_reg        <= kb_next;
        t_reg         <= t_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        alpha_out_reg <= alpha_out_next;
        beta_out_reg  <= beta_out_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ape_checker.sv =====
`default_nettype none

module ape_checker
    import ape_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [AddrW-1:0]  paddr,
    input wire logic [DataW-1:0]  pwdata,
    input wire logic [DataW-1:0]  prdata
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // valid falls only after a completed transaction
    a_out_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result withdrawn without handshake");

    // one transaction at a time: busy right after acceptance
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // a gain register reads back what was written
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr == '0)
        |=> (paddr != '0) || (prdata == $past(pwdata)))
        else $error("register readback mismatch");

endmodule

bind adaptive_param_estimator_1d_core ape_checker u_ape_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

`default_nettype wire

// ===== sim/adaptive_param_estimator_1d_core_tb.sv =====
module adaptive_param_estimator_1d_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ape_pkg::*;

    // Register indexes that the block does not decode; writes to them must be dropped.
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;

    // Quiet cycles allowed before the run is declared hung. The longest
    // legal quiet stretch is the receiver hold-off below plus one item.
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 3000;
    localparam int SETTLE_CYCLES   = 40;

    typedef struct {
        logic signed [DataW-1:0] accel;
        logic signed [DataW-1:0] drive;
        logic        [DataW-1:0] period;
        logic                    reload;
    } sample_t;

    typedef struct {
        logic [DataW-1:0] alpha;
        logic [DataW-1:0] beta;
    } estimate_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
    logic [DataW-1:0] prdata;
    logic             pready;

    ape_in_if  in_if ();
    ape_out_if out_if ();

    adaptive_param_estimator_1d_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Mirror of the register file and of the estimator state.
    logic [DataW-1:0] gain_alpha;
    logic [DataW-1:0] gain_beta;
    longint           beta_low;
    longint           beta_high;
    longint           init_alpha;
    longint           init_beta;
    longint           alpha_est;
    longint           beta_est;

    // Simulated plant that the well-formed sequences come from.
    longint           plant_alpha;
    longint           plant_beta;

    estimate_t        estimate_q[$];

    int               errors          = 0;
    int               items_sent      = 0;
    int               results_checked = 0;
    int               reg_writes      = 0;
    int               settings_used   = 1;
    int               tx_idle_pct     = 0;
    int               rx_idle_pct     = 0;
    int               hold_request    = 0;
    int               rx_wait         = 0;
    int               quiet_cycles    = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clip32(input longint v);
        if (v > MAX32)
            return MAX32;
        if (v < MIN32)
            return MIN32;
        return v;
    endfunction

    // Advance the estimator mirror by one transaction and return the new alpha/beta.
    function automatic estimate_t lms_update(input sample_t s);
        longint           drv;
        longint           acc;
        longint           pred;
        longint           err;
        longint           ka;
        longint           kb;
        longint           da;
        longint           t;
        longint           db;
        longint           a;
        longint           b;
        logic [DataW-1:0] rem;
        logic [DataW-1:0] root;
        logic [DataW-1:0] bitv;
        estimate_t        r;

        if (s.reload)
        begin
            alpha_est = init_alpha;
            beta_est  = init_beta;
        end

        drv  = s.drive;
        acc  = s.accel;
        pred = (beta_est * drv) >>> 16;
        err  = clip32(acc - (alpha_est + pred));

        // Integer square root, two bits of the radicand per pass.
        rem  = s.period;
        root = '0;
        bitv = 32'h4000_0000;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end

        ka = (longint'(gain_alpha) * longint'(root)) >>> 16;
        kb = (longint'(gain_beta) * longint'(root)) >>> 16;
        da = (ka * err) >>> 32;
        a  = clip32(alpha_est + da);

        t  = (kb * drv) >>> 32;
        db = (t * err) >>> 16;
        b  = beta_est + db;
        // Lower bound first, so crossed bounds leave beta at the upper one.
        if (b < beta_low)
            b = beta_low;
        if (b > beta_high)
            b = beta_high;

        alpha_est = a;
        beta_est  = b;
        r.alpha   = a[DataW-1:0];
        r.beta    = b[DataW-1:0];
        return r;
    endfunction

    function automatic sample_t sample_of(input logic [DataW-1:0] accel,
                                          input logic [DataW-1:0] drive,
                                          input logic [DataW-1:0] period,
                                          input logic reload);
        sample_t s;
        s.accel  = accel;
        s.drive  = drive;
        s.period = period;
        s.reload = reload;
        return s;
    endfunction

    // Mostly plant-consistent samples so the estimate actually tracks;
    // one in ten is raw noise over the full range of every field.
    function automatic sample_t random_sample();
        sample_t s;
        longint  dr;
        longint  ac;
        if ($urandom_range(1, 100) <= 10)
        begin
            s.accel  = $urandom;
            s.drive  = $urandom;
            s.period = $urandom;
            s.reload = $urandom_range(0, 1);
        end
        else
        begin
            dr = longint'($urandom_range(0, 524288)) - 64'sd262144;
            ac = plant_alpha + ((plant_beta * dr) >>> 16)
                 + longint'($urandom_range(0, 2048)) - 64'sd1024;
            s.drive  = dr[DataW-1:0];
            s.accel  = ac[DataW-1:0];
            // 1 ms to 50 ms sample period
            s.period = $urandom_range(4294967, 214748365);
            s.reload = ($urandom_range(0, 49) == 0);
        end
        return s;
    endfunction

    // Offer one transaction, hold it until taken, then record its expected result.
    task automatic send_sample(input sample_t s);
        if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_if.valid  <= 1'b1;
        in_if.accel  <= s.accel;
        in_if.drive  <= s.drive;
        in_if.period <= s.period;
        in_if.reload <= s.reload;
        do
            @(posedge clk);
        while (!(in_if.valid && in_if.ready));
        estimate_q.push_back(lms_update(s));
        items_sent++;
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (estimate_q.size() != 0)
            @(posedge clk);
    endtask

    // APB write, then read the register back where it is decoded.
    task automatic reg_write(input logic [2:0] idx, input logic [DataW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        reg_writes++;

        case (idx)
            REG_GAIN_ALPHA: gain_alpha = value;
            REG_GAIN_BETA:  gain_beta  = value;
            REG_BETA_LOW:   beta_low   = $signed(value);
            REG_BETA_HIGH:  beta_high  = $signed(value);
            REG_INIT_ALPHA: init_alpha = $signed(value);
            REG_INIT_BETA:  init_beta  = $signed(value);
            default: ;
        endcase

        if (idx <= REG_INIT_BETA)
        begin
            pwrite  <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            if (prdata !== value)
            begin
                $display("%0t: readback of register %0d, expected %h got %h",
                         $time, idx, value, prdata);
                errors++;
            end
        end

        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [DataW-1:0] ga, input logic [DataW-1:0] gb,
                             input logic [DataW-1:0] lo, input logic [DataW-1:0] hi,
                             input logic [DataW-1:0] ia, input logic [DataW-1:0] ib);
        drain();
        reg_write(REG_GAIN_ALPHA, ga);
        reg_write(REG_GAIN_BETA, gb);
        reg_write(REG_BETA_LOW, lo);
        reg_write(REG_BETA_HIGH, hi);
        reg_write(REG_INIT_ALPHA, ia);
        reg_write(REG_INIT_BETA, ib);
        settings_used++;
    endtask

    // Field extremes, saturation of the error, root of zero, one and all ones.
    task automatic test_corner_items();
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        send_sample(sample_of(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0));
        send_sample(sample_of(32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
        send_sample(sample_of(32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
        send_sample(sample_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        send_sample(sample_of(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
        send_sample(sample_of(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_sample(sample_of(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0));
        send_sample(sample_of(32'h0000_0000, 32'h0001_0000, 32'h4000_0000, 1'b1));
        send_sample(sample_of(32'h0002_0000, 32'h0001_0000, 32'h028F_5C29, 1'b0));
        send_sample(sample_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0003, 1'b0));
        send_sample(sample_of(32'h0001_8000, 32'hFFFF_0000, 32'h0041_8937, 1'b0));
        send_sample(sample_of(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        send_sample(sample_of(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1));
        send_sample(sample_of(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0));
        plant_alpha = 64'sd32768;
        plant_beta  = 64'sd98304;
        repeat (4)
            send_sample(random_sample());
    endtask

    // Zero gains, init writes without reload, saturating alpha, crossed
    // bounds and writes to undecoded indexes.
    task automatic test_register_effects();
        drain();
        reg_write(REG_GAIN_ALPHA, 32'h0000_0000);
        reg_write(REG_GAIN_BETA, 32'h0000_0000);
        repeat (3)
            send_sample(random_sample());

        // Init registers must only take effect on the next reload.
        drain();
        reg_write(REG_INIT_ALPHA, 32'h7FFF_FFFF);
        reg_write(REG_INIT_BETA, 32'h8000_0000);
        send_sample(sample_of(32'h0001_0000, 32'h0001_0000, 32'h0100_0000, 1'b0));
        send_sample(sample_of(32'h0001_0000, 32'h0001_0000, 32'h0100_0000, 1'b0));
        send_sample(sample_of(32'h0001_0000, 32'h0001_0000, 32'h0100_0000, 1'b1));

        // Full gains and open bounds: drive alpha into saturation both ways.
        drain();
        reg_write(REG_GAIN_ALPHA, 32'hFFFF_FFFF);
        reg_write(REG_GAIN_BETA, 32'hFFFF_FFFF);
        reg_write(REG_BETA_LOW, 32'h8000_0000);
        reg_write(REG_BETA_HIGH, 32'h7FFF_FFFF);
        send_sample(sample_of(32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
        send_sample(sample_of(32'h7FFF_FFFF, 32'h0000_1000, 32'hFFFF_FFFF, 1'b0));
        send_sample(sample_of(32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
        send_sample(sample_of(32'h8000_0000, 32'hFFFF_F000, 32'hFFFF_FFFF, 1'b0));

        // Crossed bounds: beta must settle on the upper bound.
        drain();
        reg_write(REG_BETA_LOW, 32'h0002_0000);
        reg_write(REG_BETA_HIGH, 32'h0000_199A);
        reg_write(REG_INIT_ALPHA, 32'h0000_0000);
        reg_write(REG_INIT_BETA, 32'h0001_0000);
        send_sample(sample_of(32'h0003_0000, 32'h0001_0000, 32'h0400_0000, 1'b1));
        send_sample(sample_of(32'hFFFD_0000, 32'h0001_0000, 32'h0400_0000, 1'b0));
        send_sample(sample_of(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1));

        // Undecoded indexes: nothing may change.
        drain();
        reg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
        reg_write(REG_SPARE_HI, 32'h0000_0000);
        send_sample(sample_of(32'h0001_0000, 32'h0000_8000, 32'h0200_0000, 1'b1));
        send_sample(sample_of(32'h0000_8000, 32'h0001_0000, 32'h0200_0000, 1'b0));
        settings_used += 4;
    endtask

    task automatic run_phase(input logic [DataW-1:0] ga, input logic [DataW-1:0] gb,
                             input logic [DataW-1:0] lo, input logic [DataW-1:0] hi,
                             input logic [DataW-1:0] ia, input logic [DataW-1:0] ib,
                             input int tx_pct, input int rx_pct, input int count);
        configure(ga, gb, lo, hi, ia, ib);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        plant_alpha = longint'($urandom_range(0, 524288)) - 64'sd262144;
        plant_beta  = longint'($urandom_range(6554, 131072));
        send_sample(sample_of(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1));
        repeat (count - 1)
            send_sample(random_sample());
    endtask

    // Track simulated plants under several gain and bound settings.
    task automatic test_tracking();
        run_phase(RST_GAIN_ALPHA, RST_GAIN_BETA, RST_BETA_LOW, RST_BETA_HIGH,
                  RST_INIT_ALPHA, RST_INIT_BETA, 25, 25, 220);
        run_phase(32'h1000_0000, 32'h4000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'hFFFE_8000, 32'h0001_8000, 10, 40, 220);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFC_0000, 32'h0004_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 40, 10, 220);
        run_phase(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0003_0000,
                  32'h0000_0000, 32'h0001_0000, 0, 0, 160);
    endtask

    // Hold the receiver off for a long stretch while the sender keeps
    // offering, so the block fills up and stalls its input.
    task automatic test_backpressure();
        drain();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = HOLD_OFF_CYCLES;
        repeat (40)
            send_sample(random_sample());
    endtask

    // Back-to-back at full rate on both sides, reset settings restored.
    task automatic test_full_rate();
        configure(RST_GAIN_ALPHA, RST_GAIN_BETA, RST_BETA_LOW, RST_BETA_HIGH,
                  RST_INIT_ALPHA, RST_INIT_BETA);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (150)
            send_sample(random_sample());
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            rx_wait      = hold_request;
            hold_request = 0;
        end
        if (rx_wait > 0)
        begin
            rx_wait--;
            out_if.ready <= 1'b0;
        end
        else if (rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct)
        begin
            rx_wait = $urandom_range(0, 8);
            out_if.ready <= 1'b0;
        end
        else
            out_if.ready <= 1'b1;
    end

    // Compare every output transaction against the oldest expected estimate.
    always @(posedge clk)
    begin : check_result
        estimate_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            results_checked++;
            if (estimate_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none got alpha_out=%h beta_out=%h",
                         $time, out_if.alpha_out, out_if.beta_out);
                errors++;
            end
            else
            begin
                want = estimate_q.pop_front();
                if (out_if.alpha_out !== want.alpha)
                begin
                    $display("%0t: alpha_out mismatch, expected %h got %h",
                             $time, want.alpha, out_if.alpha_out);
                    errors++;
                end
                if (out_if.beta_out !== want.beta)
                begin
                    $display("%0t: beta_out mismatch, expected %h got %h",
                             $time, want.beta, out_if.beta_out);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, estimate_q.size());
                $display("adaptive_param_estimator_1d_core_tb: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_if.valid  = 1'b0;
        in_if.accel  = '0;
        in_if.drive  = '0;
        in_if.period = '0;
        in_if.reload = 1'b0;
        out_if.ready = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;

        gain_alpha  = RST_GAIN_ALPHA;
        gain_beta   = RST_GAIN_BETA;
        beta_low    = $signed(RST_BETA_LOW);
        beta_high   = $signed(RST_BETA_HIGH);
        init_alpha  = $signed(RST_INIT_ALPHA);
        init_beta   = $signed(RST_INIT_BETA);
        alpha_est   = init_alpha;
        beta_est    = init_beta;
        plant_alpha = 0;
        plant_beta  = 64'sd65536;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_items();
        test_register_effects();
        test_tracking();
        test_backpressure();
        test_full_rate();

        // Let everything come back, then watch for strays.
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d transactions in, %0d results checked, %0d register writes",
                 items_sent, results_checked, reg_writes);
        $display("across %0d gain/bound settings, incl. crossed bounds and a long output stall",
                 settings_used);
        if (errors == 0)
            $display("adaptive_param_estimator_1d_core_tb: done, clean");
        else
            $display("adaptive_param_estimator_1d_core_tb: done, errors");
        $finish;
    end

endmodule
